// ===== design/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master engine package
// Shared types and codes for the I2C master sequencer and its pipeline stages.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command codes carried with each input transfer.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Completion status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ADDR_NACK = 2'd1;
  localparam logic [1:0] STATUS_DATA_NACK = 2'd2;

  // Sequencer phases, one pin change per tick.
  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_START_SCL  = 5'd1,
    PH_W_SETUP    = 5'd2,
    PH_W_HIGH     = 5'd3,
    PH_W_LOW      = 5'd4,
    PH_ACK_REL    = 5'd5,
    PH_ACK_HIGH   = 5'd6,
    PH_ACK_SAMPLE = 5'd7,
    PH_ACK_TAKE   = 5'd8,
    PH_LOAD       = 5'd9,
    PH_R_REL      = 5'd10,
    PH_R_HIGH     = 5'd11,
    PH_R_SAMPLE   = 5'd12,
    PH_MA_SET     = 5'd13,
    PH_MA_HIGH    = 5'd14,
    PH_MA_LOW     = 5'd15,
    PH_MA_REL     = 5'd16,
    PH_STOP_PULL  = 5'd17,
    PH_STOP_SCL   = 5'd18,
    PH_STOP_SDA   = 5'd19
  } phase_t;

  // One input tick.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_count;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  // One result tick.
  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       byte_request;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } res_item_t;

endpackage

// ===== design/i2cm_in_stage.sv =====
// ----------------------------------------------------------------------------
// I2C master input stage
// Registers one incoming tick and holds it until the sequencer consumes it.
// ----------------------------------------------------------------------------
module i2cm_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  i2cm_pkg::in_item_t in_item,
  input  logic               advance,
  output logic               item_valid,
  output i2cm_pkg::in_item_t item
);
  import i2cm_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // The stage frees up whenever its current tick moves on.
  assign in_stall   = valid_r && !advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== design/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// I2C master sequencer
// Phase state machine that advances one pin change per consumed tick.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  i2cm_pkg::in_item_t  item,
  input  logic [6:0]          slave_address,
  output i2cm_pkg::res_item_t res
);
  import i2cm_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_index_r, bit_index_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       reading_r, reading_nxt;
  logic [1:0] status_r, status_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;

  logic [3:0] bit_inc;
  logic [7:0] rx_shift;
  logic [7:0] bytes_dec;
  logic       req, rx_valid, rx_last, done;
  logic [7:0] rx_byte;

  assign bit_inc   = bit_index_r + 4'd1;
  assign rx_shift  = {shift_r[6:0], item.sda_in};
  assign bytes_dec = bytes_left_r - 8'd1;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (item.command inside {CMD_WRITE, CMD_READ}) begin
          phase_nxt = PH_START_SCL;
        end
      end
      PH_START_SCL:  phase_nxt = PH_W_SETUP;
      PH_LOAD:       phase_nxt = PH_W_HIGH;
      PH_W_SETUP:    phase_nxt = PH_W_HIGH;
      PH_W_HIGH:     phase_nxt = PH_W_LOW;
      PH_W_LOW:      phase_nxt = bit_inc[3] ? PH_ACK_REL : PH_W_SETUP;
      PH_ACK_REL:    phase_nxt = PH_ACK_HIGH;
      PH_ACK_HIGH:   phase_nxt = PH_ACK_SAMPLE;
      PH_ACK_SAMPLE: phase_nxt = PH_ACK_TAKE;
      PH_ACK_TAKE: begin
        if (status_r != STATUS_OK || bytes_left_r == 8'd0) begin
          phase_nxt = PH_STOP_SCL;
        end else if (reading_r) begin
          phase_nxt = PH_R_REL;
        end else begin
          phase_nxt = PH_LOAD;
        end
      end
      PH_R_REL, PH_MA_REL: phase_nxt = PH_R_HIGH;
      PH_R_HIGH:     phase_nxt = PH_R_SAMPLE;
      PH_R_SAMPLE:   phase_nxt = bit_inc[3] ? PH_MA_SET : PH_R_HIGH;
      PH_MA_SET:     phase_nxt = PH_MA_HIGH;
      PH_MA_HIGH:    phase_nxt = PH_MA_LOW;
      PH_MA_LOW:     phase_nxt = (bytes_left_r != 8'd0) ? PH_MA_REL : PH_STOP_PULL;
      PH_STOP_PULL:  phase_nxt = PH_STOP_SCL;
      PH_STOP_SCL:   phase_nxt = PH_STOP_SDA;
      PH_STOP_SDA:   phase_nxt = PH_IDLE;
      default:       phase_nxt = PH_IDLE;
    endcase
  end

  // Datapath and per-tick outputs.
  always_comb begin
    bit_index_nxt  = bit_index_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    reading_nxt    = reading_r;
    status_nxt     = status_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    req            = 1'b0;
    rx_valid       = 1'b0;
    rx_last        = 1'b0;
    rx_byte        = 8'd0;
    done           = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (item.command inside {CMD_WRITE, CMD_READ}) begin
          reading_nxt    = (item.command == CMD_READ);
          bytes_left_nxt = item.byte_count;
          status_nxt     = STATUS_ADDR_NACK;
          shift_nxt      = {slave_address, (item.command == CMD_READ)};
          bit_index_nxt  = 4'd0;
          sda_nxt        = 1'b1;
        end
      end
      PH_START_SCL: begin
        scl_nxt       = 1'b1;
        bit_index_nxt = 4'd0;
      end
      PH_LOAD: begin
        shift_nxt      = item.tx_byte;
        bytes_left_nxt = bytes_dec;
        bit_index_nxt  = 4'd0;
        sda_nxt        = !item.tx_byte[7];
      end
      PH_W_SETUP:  sda_nxt = !shift_r[7];
      PH_W_HIGH:   scl_nxt = 1'b0;
      PH_W_LOW: begin
        scl_nxt       = 1'b1;
        shift_nxt     = {shift_r[6:0], 1'b0};
        bit_index_nxt = bit_inc;
      end
      PH_ACK_REL:  sda_nxt = 1'b0;
      PH_ACK_HIGH: scl_nxt = 1'b0;
      PH_ACK_SAMPLE: begin
        scl_nxt = 1'b1;
        // A NACK during the address keeps the address code; later it is a data NACK.
        if (item.sda_in) begin
          status_nxt = (status_r == STATUS_ADDR_NACK) ? STATUS_ADDR_NACK
                                                      : STATUS_DATA_NACK;
        end else if (status_r == STATUS_ADDR_NACK) begin
          status_nxt = STATUS_OK;
        end
      end
      PH_ACK_TAKE: begin
        sda_nxt = 1'b1;
        if (status_r == STATUS_OK && bytes_left_r != 8'd0 && !reading_r) begin
          req = 1'b1;
        end
      end
      PH_R_REL, PH_MA_REL: begin
        sda_nxt       = 1'b0;
        shift_nxt     = 8'd0;
        bit_index_nxt = 4'd0;
      end
      PH_R_HIGH: scl_nxt = 1'b0;
      PH_R_SAMPLE: begin
        scl_nxt       = 1'b1;
        shift_nxt     = rx_shift;
        bit_index_nxt = bit_inc;
        if (bit_inc[3]) begin
          bytes_left_nxt = bytes_dec;
          rx_byte        = rx_shift;
          rx_valid       = 1'b1;
          rx_last        = (bytes_dec == 8'd0);
        end
      end
      PH_MA_SET:    sda_nxt = (bytes_left_r != 8'd0);
      PH_MA_HIGH:   scl_nxt = 1'b0;
      PH_MA_LOW:    scl_nxt = 1'b1;
      PH_STOP_PULL: sda_nxt = 1'b1;
      PH_STOP_SCL:  scl_nxt = 1'b0;
      PH_STOP_SDA: begin
        sda_nxt = 1'b0;
        done    = 1'b1;
      end
      default: begin
        scl_nxt = 1'b0;
        sda_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_index_r  <= 4'd0;
      shift_r      <= 8'd0;
      bytes_left_r <= 8'd0;
      reading_r    <= 1'b0;
      status_r     <= STATUS_OK;
      scl_r        <= 1'b0;
      sda_r        <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      reading_r    <= reading_nxt;
      status_r     <= status_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
    end
  end

  always_comb begin
    res.scl_low      = scl_nxt;
    res.sda_low      = sda_nxt;
    res.byte_request = req;
    res.rx_byte      = rx_byte;
    res.rx_valid     = rx_valid;
    res.rx_last      = rx_last;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.done_res     = done;
    res.status       = (phase_nxt != PH_IDLE) ? STATUS_OK : status_nxt;
  end

endmodule

// ===== design/i2cm_out_stage.sv =====
// ----------------------------------------------------------------------------
// I2C master output stage
// Result register that holds a finished tick until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cm_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  i2cm_pkg::res_item_t res,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::res_item_t out_res
);
  import i2cm_pkg::*;

  logic      valid_r;
  res_item_t res_r;

  // A new result may load when the register is empty or is being drained.
  assign advance   = item_valid && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

endmodule

// ===== design/i2c_master_transfer_engine_top.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer engine
// Open-drain I2C master sequencer that makes one pin change per input tick.
// ----------------------------------------------------------------------------
// Usage: every transfer on the input channel is one tick of the bus clock
// divider. Command 1 or 2 on an idle engine begins a write or read of
// in_byte_count bytes to the address held in the configuration register;
// other ticks just step the sequencer. Every input transfer yields exactly
// one output transfer carrying the line drives, byte request, received
// byte and status for that tick.
// The configuration channel (cfg_valid/cfg_ready) writes the seven-bit
// slave address; it is always ready and should be written while idle.
// Pipeline: an accepted tick is held in the input register and then moves
// through the sequencer into the result register, from which it is offered
// to the receiver. Throughput is one tick per cycle while the receiver takes
// each result, set by the phase update of the sequencer state. When the
// receiver raises out_stall the result register holds its value and, once
// the input register is also full, in_stall rises. Synchronous reset
// empties both registers, returns the sequencer to idle with both lines
// released and clears the slave address to zero.
// ----------------------------------------------------------------------------
module i2c_master_transfer_engine_top (
  input  logic       clk,
  input  logic       rst_n,
  // Input tick channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_byte_count,
  input  logic [7:0] in_tx_byte,
  input  logic       in_sda_in,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_low,
  output logic       out_sda_low,
  output logic       out_byte_request,
  output logic [7:0] out_rx_byte,
  output logic       out_rx_valid,
  output logic       out_rx_last,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [1:0] out_status,
  // Configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);
  import i2cm_pkg::*;

  in_item_t   in_item;
  in_item_t   item;
  logic       item_valid;
  logic       advance;
  res_item_t  res;
  res_item_t  out_res;
  logic [6:0] slave_address_r;

  // Gather the input fields into one item.
  assign in_item.command    = in_command;
  assign in_item.byte_count = in_byte_count;
  assign in_item.tx_byte    = in_tx_byte;
  assign in_item.sda_in     = in_sda_in;

  // The address register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= 7'd0;
    end else if (cfg_valid && cfg_ready) begin
      slave_address_r <= cfg_data;
    end
  end

  i2cm_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // The sequencer state moves only when a tick goes into the result register.
  i2cm_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .item          (item),
    .slave_address (slave_address_r),
    .res           (res)
  );

  i2cm_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  // Scatter the result item onto the output ports.
  assign out_scl_low      = out_res.scl_low;
  assign out_sda_low      = out_res.sda_low;
  assign out_byte_request = out_res.byte_request;
  assign out_rx_byte      = out_res.rx_byte;
  assign out_rx_valid     = out_res.rx_valid;
  assign out_rx_last      = out_res.rx_last;
  assign out_busy_res     = out_res.busy_res;
  assign out_done_res     = out_res.done_res;
  assign out_status       = out_res.status;

`ifndef SYNTH
  // A received byte is always followed by its ack clock, so the engine is busy.
  a_rx_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rx_valid) |-> out_busy_res)
    else $error("received byte reported while engine idle");

  // The stop completes with both lines released and the engine idle.
  a_done_released: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (!out_busy_res && !out_scl_low && !out_sda_low))
    else $error("stop completed with a line still driven or engine busy");

  // A byte request is only made mid-transfer with SCL held low.
  a_req_scl_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_request) |-> (out_busy_res && out_scl_low && out_status == STATUS_OK))
    else $error("byte request outside a running write");
`endif

endmodule

// ===== tb/i2c_master_transfer_engine_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master transfer engine testbench
// Drives bus ticks into the engine while playing the slave side of the bus,
// predicts every result tick with a cycle-accurate sequencer model and
// compares each result transfer field by field against that prediction.
// ----------------------------------------------------------------------------
module i2c_master_transfer_engine_top_tb;
  import i2cm_pkg::*;

  // Command code 3 has no meaning and must behave as a plain tick.
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  // Run is abandoned after this many clock cycles.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles to let pass after the last expected result before touching config.
  localparam int SETTLE_CYCLES = 6;
  // Acknowledge slot index meaning "the slave acknowledges everything".
  localparam int NO_NACK = -1;
  // Number of random-part input transfers.
  localparam int RANDOM_TICKS = 1000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_command;
  logic [7:0] in_byte_count;
  logic [7:0] in_tx_byte;
  logic       in_sda_in;
  logic       out_valid;
  logic       out_stall;
  logic       out_scl_low;
  logic       out_sda_low;
  logic       out_byte_request;
  logic [7:0] out_rx_byte;
  logic       out_rx_valid;
  logic       out_rx_last;
  logic       out_busy_res;
  logic       out_done_res;
  logic [1:0] out_status;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_data;

  i2c_master_transfer_engine_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_byte_count    (in_byte_count),
    .in_tx_byte       (in_tx_byte),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl_low      (out_scl_low),
    .out_sda_low      (out_sda_low),
    .out_byte_request (out_byte_request),
    .out_rx_byte      (out_rx_byte),
    .out_rx_valid     (out_rx_valid),
    .out_rx_last      (out_rx_last),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Sequencer model state. It mirrors the engine's state after every input
  // transfer accepted so far, so the stimulus side can also look at it to
  // know which bus phase the next tick lands in.
  // --------------------------------------------------------------------------
  phase_t     seq_phase;
  logic [3:0] seq_bit_idx;
  logic [7:0] seq_shift;
  logic [7:0] seq_bytes_left;
  logic       seq_reading;
  logic [1:0] seq_status;
  logic       seq_scl_low;
  logic       seq_sda_low;
  logic [6:0] seq_slave_addr;

  // Result ticks predicted but not yet seen on the output channel.
  res_item_t  pending_ticks[$];
  res_item_t  expected_tick;

  // Slave-side scripting: bytes the slave returns on reads, bytes fed to
  // tx_byte on loads, and which acknowledge slot of a transfer gets a NACK
  // (slot 0 is the address, slot n is data byte n).
  logic [7:0] slave_bytes[$];
  logic [7:0] write_bytes[$];
  logic [7:0] slave_cur;
  int         ack_seen;
  int         nack_slot;

  int err_count   = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  // Cycles of forced receiver hold-off still to go.
  int hold_left   = 0;
  // When set, neither side idles.
  bit steady      = 1'b0;

  // --------------------------------------------------------------------------
  // Clock.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predict one result tick and advance the model by one input tick.
  // --------------------------------------------------------------------------
  function automatic res_item_t advance_sequencer(in_item_t it);
    res_item_t r;
    r = '0;
    case (seq_phase)
      PH_IDLE: begin
        // Only an idle engine reacts to a begin command.
        if (it.command == CMD_WRITE || it.command == CMD_READ) begin
          seq_reading    = (it.command == CMD_READ);
          seq_bytes_left = it.byte_count;
          seq_status     = STATUS_ADDR_NACK;
          seq_shift      = {seq_slave_addr, seq_reading};
          seq_bit_idx    = 4'd0;
          seq_sda_low    = 1'b1;
          seq_phase      = PH_START_SCL;
        end
      end
      PH_START_SCL: begin
        seq_scl_low = 1'b1;
        seq_bit_idx = 4'd0;
        seq_phase   = PH_W_SETUP;
      end
      PH_LOAD: begin
        seq_shift      = it.tx_byte;
        seq_bytes_left = seq_bytes_left - 8'd1;
        seq_bit_idx    = 4'd0;
        seq_sda_low    = !seq_shift[7];
        seq_phase      = PH_W_HIGH;
      end
      PH_W_SETUP: begin
        seq_sda_low = !seq_shift[7];
        seq_phase   = PH_W_HIGH;
      end
      PH_W_HIGH: begin
        seq_scl_low = 1'b0;
        seq_phase   = PH_W_LOW;
      end
      PH_W_LOW: begin
        seq_scl_low = 1'b1;
        seq_shift   = seq_shift << 1;
        seq_bit_idx = seq_bit_idx + 4'd1;
        seq_phase   = (seq_bit_idx >= 4'd8) ? PH_ACK_REL : PH_W_SETUP;
      end
      PH_ACK_REL: begin
        seq_sda_low = 1'b0;
        seq_phase   = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        seq_scl_low = 1'b0;
        seq_phase   = PH_ACK_SAMPLE;
      end
      PH_ACK_SAMPLE: begin
        seq_scl_low = 1'b1;
        // A pending address NACK stays an address NACK; otherwise a high
        // line in the acknowledge slot is a data NACK.
        if (it.sda_in) begin
          seq_status = (seq_status == STATUS_ADDR_NACK) ? STATUS_ADDR_NACK
                                                        : STATUS_DATA_NACK;
        end else if (seq_status == STATUS_ADDR_NACK) begin
          seq_status = STATUS_OK;
        end
        seq_phase = PH_ACK_TAKE;
      end
      PH_ACK_TAKE: begin
        seq_sda_low = 1'b1;
        if (seq_status != STATUS_OK || seq_bytes_left == 8'd0) begin
          seq_phase = PH_STOP_SCL;
        end else if (seq_reading) begin
          seq_phase = PH_R_REL;
        end else begin
          r.byte_request = 1'b1;
          seq_phase      = PH_LOAD;
        end
      end
      PH_R_REL, PH_MA_REL: begin
        seq_sda_low = 1'b0;
        seq_shift   = 8'd0;
        seq_bit_idx = 4'd0;
        seq_phase   = PH_R_HIGH;
      end
      PH_R_HIGH: begin
        seq_scl_low = 1'b0;
        seq_phase   = PH_R_SAMPLE;
      end
      PH_R_SAMPLE: begin
        seq_scl_low = 1'b1;
        seq_shift   = {seq_shift[6:0], it.sda_in};
        seq_bit_idx = seq_bit_idx + 4'd1;
        if (seq_bit_idx >= 4'd8) begin
          seq_bytes_left = seq_bytes_left - 8'd1;
          r.rx_byte      = seq_shift;
          r.rx_valid     = 1'b1;
          r.rx_last      = (seq_bytes_left == 8'd0);
          seq_phase      = PH_MA_SET;
        end else begin
          seq_phase = PH_R_HIGH;
        end
      end
      PH_MA_SET: begin
        // Ack every byte but the last, which gets a NACK.
        seq_sda_low = (seq_bytes_left != 8'd0);
        seq_phase   = PH_MA_HIGH;
      end
      PH_MA_HIGH: begin
        seq_scl_low = 1'b0;
        seq_phase   = PH_MA_LOW;
      end
      PH_MA_LOW: begin
        seq_scl_low = 1'b1;
        seq_phase   = (seq_bytes_left != 8'd0) ? PH_MA_REL : PH_STOP_PULL;
      end
      PH_STOP_PULL: begin
        seq_sda_low = 1'b1;
        seq_phase   = PH_STOP_SCL;
      end
      PH_STOP_SCL: begin
        seq_scl_low = 1'b0;
        seq_phase   = PH_STOP_SDA;
      end
      PH_STOP_SDA: begin
        seq_sda_low = 1'b0;
        r.done_res  = 1'b1;
        seq_phase   = PH_IDLE;
      end
      default: begin
        seq_scl_low = 1'b0;
        seq_sda_low = 1'b0;
        seq_phase   = PH_IDLE;
      end
    endcase
    r.scl_low  = seq_scl_low;
    r.sda_low  = seq_sda_low;
    r.busy_res = (seq_phase != PH_IDLE);
    // Status is only reported once the engine is idle again.
    r.status   = r.busy_res ? STATUS_OK : seq_status;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Offer one tick on the input channel and predict its result once it is
  // accepted. in_valid is left high on return; the next call either keeps
  // it high for the next tick or drops it for an idle gap.
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic [1:0] cmd, input logic [7:0] count,
                           input logic [7:0] txb, input logic sda);
    in_item_t it;
    it.command    = cmd;
    it.byte_count = count;
    it.tx_byte    = txb;
    it.sda_in     = sda;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_byte_count <= count;
    in_tx_byte    <= txb;
    in_sda_in     <= sda;
    do @(posedge clk); while (in_stall);
    pending_ticks.push_back(advance_sequencer(it));
    items_sent++;
  endtask

  // One tick of an ongoing transfer, with the slave answering on the lines
  // as the current bus phase calls for. With noise on, some ticks carry
  // begin commands, which a busy engine must ignore, and a few acks flip.
  task automatic tick_slave(input bit noisy);
    logic [1:0] cmd;
    logic [7:0] txb;
    logic       sda;
    cmd = CMD_TICK;
    if (noisy && $urandom_range(99) < 15) cmd = 2'($urandom_range(3));
    txb = 8'($urandom_range(255));
    sda = 1'($urandom_range(1));
    case (seq_phase)
      PH_LOAD: begin
        if (write_bytes.size() > 0) txb = write_bytes.pop_front();
      end
      PH_ACK_SAMPLE: begin
        sda = (ack_seen == nack_slot);
        if (noisy && $urandom_range(99) < 4) sda = !sda;
        ack_seen++;
      end
      PH_R_SAMPLE: begin
        if (seq_bit_idx == 4'd0) begin
          if (slave_bytes.size() > 0) slave_cur = slave_bytes.pop_front();
          else slave_cur = 8'($urandom_range(255));
        end
        sda = slave_cur[3'd7 - seq_bit_idx[2:0]];
      end
      default: ;
    endcase
    send_tick(cmd, 8'($urandom_range(255)), txb, sda);
  endtask

  // A whole bus transfer, from the begin command until the engine is idle.
  task automatic run_transfer(input logic [1:0] cmd, input logic [7:0] count,
                              input int nack_at, input bit noisy);
    ack_seen  = 0;
    nack_slot = nack_at;
    send_tick(cmd, count, 8'($urandom_range(255)), 1'($urandom_range(1)));
    while (seq_phase != PH_IDLE) tick_slave(noisy);
  endtask

  // Ticks on an idle engine; none of them may start a transfer.
  task automatic idle_ticks(input int n);
    repeat (n) begin
      send_tick($urandom_range(1) ? CMD_RESERVED : CMD_TICK,
                8'($urandom_range(255)), 8'($urandom_range(255)),
                1'($urandom_range(1)));
    end
  endtask

  // Stop offering ticks and wait until every predicted result has arrived,
  // plus a settling wait for anything still in the pipeline.
  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_ticks.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Program the slave address; only called with the sequencer idle.
  task automatic write_address(input logic [6:0] addr);
    wait_results();
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    seq_slave_addr = addr;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed tests.
  // --------------------------------------------------------------------------

  // Plain and reserved ticks with extreme field values leave the engine idle.
  task automatic test_idle_ticks();
    send_tick(CMD_TICK, 8'h00, 8'h00, 1'b0);
    send_tick(CMD_RESERVED, 8'hFF, 8'hFF, 1'b1);
    send_tick(CMD_RESERVED, 8'h00, 8'h00, 1'b0);
    send_tick(CMD_TICK, 8'hFF, 8'hFF, 1'b1);
  endtask

  // Fully acknowledged write with all-zero and all-one data bytes.
  task automatic test_write_ok();
    write_address(7'h7F);
    write_bytes = '{8'h00, 8'hFF, 8'hA5};
    run_transfer(CMD_WRITE, 8'd3, NO_NACK, 1'b0);
  endtask

  // Read of three bytes: every byte acked by the master except the last.
  task automatic test_read_ok();
    write_address(7'h00);
    slave_bytes = '{8'hFF, 8'h00, 8'h5A};
    run_transfer(CMD_READ, 8'd3, NO_NACK, 1'b0);
  endtask

  // Address NACK ends the transfer with a stop, also for a long read.
  task automatic test_address_nack();
    run_transfer(CMD_WRITE, 8'd1, 0, 1'b0);
    run_transfer(CMD_READ, 8'd255, 0, 1'b0);
  endtask

  // Data NACK on the only byte and on the second byte of a long write.
  task automatic test_data_nack();
    write_address(7'h2A);
    run_transfer(CMD_WRITE, 8'd1, 1, 1'b0);
    run_transfer(CMD_WRITE, 8'd255, 2, 1'b0);
  endtask

  // Zero byte count: address only, then the stop with status ok.
  task automatic test_zero_count();
    run_transfer(CMD_WRITE, 8'd0, NO_NACK, 1'b0);
    run_transfer(CMD_READ, 8'd0, NO_NACK, 1'b0);
  endtask

  // Begin commands that arrive while a transfer runs are ignored.
  task automatic test_busy_begin();
    ack_seen  = 0;
    nack_slot = NO_NACK;
    send_tick(CMD_READ, 8'd1, 8'h00, 1'b0);
    send_tick(CMD_WRITE, 8'd9, 8'hFF, 1'b1);
    send_tick(CMD_READ, 8'd200, 8'h3C, 1'b0);
    send_tick(CMD_RESERVED, 8'd4, 8'hC3, 1'b1);
    while (seq_phase != PH_IDLE) tick_slave(1'b1);
  endtask

  // The receiver holds off for a long stretch while ticks keep coming, so
  // the pipeline fills and the engine stalls its input.
  task automatic test_backpressure();
    hold_left = 60;
    write_bytes = '{8'h81, 8'h7E};
    run_transfer(CMD_WRITE, 8'd2, NO_NACK, 1'b0);
  endtask

  // The sender pauses in the middle of a read until the output drains.
  task automatic test_pause();
    ack_seen  = 0;
    nack_slot = NO_NACK;
    send_tick(CMD_READ, 8'd2, 8'h00, 1'b0);
    repeat (20) tick_slave(1'b0);
    wait_results();
    while (seq_phase != PH_IDLE) tick_slave(1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Random transfers: mostly well-formed with small byte counts, some with
  // NACKs, a few long ones that a NACK cuts short, noise ticks between them
  // and the slave address changed every few transfers.
  // --------------------------------------------------------------------------
  task automatic test_random();
    int         start_count;
    int         pick;
    int         nack_at;
    logic [1:0] cmd;
    logic [7:0] count;
    logic [6:0] addr;
    bit         noisy;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_TICKS) begin
      // A stretch in the middle runs with no idling on either side.
      steady = (items_sent - start_count >= 600) && (items_sent - start_count < 900);
      if ($urandom_range(7) == 0) begin
        pick = $urandom_range(3);
        if (pick == 0) addr = 7'h00;
        else if (pick == 1) addr = 7'h7F;
        else addr = 7'($urandom_range(127));
        write_address(addr);
      end
      pick = $urandom_range(99);
      if (pick < 8) count = 8'd0;
      else if (pick < 92) count = 8'($urandom_range(1, 3));
      else count = 8'($urandom_range(4, 255));
      cmd     = $urandom_range(1) ? CMD_WRITE : CMD_READ;
      noisy   = ($urandom_range(99) < 40);
      nack_at = NO_NACK;
      if ($urandom_range(99) < 15) nack_at = $urandom_range(0, count);
      if (count > 8'd6) begin
        // Long transfers are cut short by a NACK and kept free of ack noise.
        nack_at = (cmd == CMD_READ) ? 0 : $urandom_range(0, 3);
        noisy   = 1'b0;
      end
      run_transfer(cmd, count, nack_at, noisy);
      idle_ticks($urandom_range(0, 3));
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a forced hold-off counted down here.
  // --------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (!steady && $urandom_range(99) < 22);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result transfer is matched against the
  // oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ticks.size() == 0) begin
        $error("result transfer with no prediction waiting");
        err_count++;
      end else begin
        expected_tick = pending_ticks.pop_front();
        check_field("scl_low", 8'(expected_tick.scl_low), 8'(out_scl_low));
        check_field("sda_low", 8'(expected_tick.sda_low), 8'(out_sda_low));
        check_field("byte_request", 8'(expected_tick.byte_request),
                    8'(out_byte_request));
        check_field("rx_byte", expected_tick.rx_byte, out_rx_byte);
        check_field("rx_valid", 8'(expected_tick.rx_valid), 8'(out_rx_valid));
        check_field("rx_last", 8'(expected_tick.rx_last), 8'(out_rx_last));
        check_field("busy_res", 8'(expected_tick.busy_res), 8'(out_busy_res));
        check_field("done_res", 8'(expected_tick.done_res), 8'(out_done_res));
        check_field("status", 8'(expected_tick.status), 8'(out_status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a hang anywhere ends the run as a failure.
  // --------------------------------------------------------------------------
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[i2c_master_transfer_engine_top] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_TICK;
    in_byte_count = 8'd0;
    in_tx_byte    = 8'd0;
    in_sda_in     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = 7'd0;

    // Model state after reset: idle, both lines released, address zero.
    seq_phase      = PH_IDLE;
    seq_bit_idx    = 4'd0;
    seq_shift      = 8'd0;
    seq_bytes_left = 8'd0;
    seq_reading    = 1'b0;
    seq_status     = STATUS_OK;
    seq_scl_low    = 1'b0;
    seq_sda_low    = 1'b0;
    seq_slave_addr = 7'd0;
    slave_cur      = 8'd0;
    ack_seen       = 0;
    nack_slot      = NO_NACK;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_write_ok();
    test_read_ok();
    test_address_nack();
    test_data_nack();
    test_zero_count();
    test_busy_begin();
    test_backpressure();
    test_pause();
    test_random();

    wait_results();
    if (err_count == 0) begin
      $display("[i2c_master_transfer_engine_top] OK");
    end else begin
      $display("[i2c_master_transfer_engine_top] ERROR");
    end
    $finish;
  end

endmodule
